// ----- src/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [1:0] {
		MODE_PUSH_BACK  = 2'd0,
		MODE_PUSH_FRONT = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ----- src/double_ended_queue.sv -----
// Double-ended queue over a ring buffer: top level with pointer control and result register.
// A transfer loads the in-flight registers; the result register takes them over once it is
// empty or its output is not stalled. The input stalls while an item waits between its
// memory read and the result register, longer while a stalled output holds that register.
// An item is still taken while a finished result waits on a stalled output.
// Reset clears head, count and all valid flags; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       mode,
	input  wire logic signed [dq_pkg::DATA_W-1:0] push_value,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [dq_pkg::DATA_W-1:0]      popped_value,
	output logic [1:0]                            status,
	output logic                                  is_empty,
	output logic                                  is_full,
	output logic signed [dq_pkg::DATA_W-1:0]      front_value,
	output logic signed [dq_pkg::DATA_W-1:0]      back_value
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] WRAP_SUM = SW'(DEPTH);

	// architectural state
	logic [IW-1:0]                    head_q;
	logic [CW-1:0]                    count_q;
	logic signed [dq_pkg::DATA_W-1:0] front_q;
	logic signed [dq_pkg::DATA_W-1:0] back_q;

	// item in flight
	logic                             valid_s1;
	logic signed [dq_pkg::DATA_W-1:0] popped_s1;
	dq_pkg::status_t                  status_s1;
	logic                             ld_front_s1;
	logic                             ld_back_s1;

	// result register
	logic                             out_valid_q;
	logic signed [dq_pkg::DATA_W-1:0] popped_q;
	dq_pkg::status_t                  status_q;
	logic                             empty_q;
	logic                             full_q;
	logic signed [dq_pkg::DATA_W-1:0] front_out_q;
	logic signed [dq_pkg::DATA_W-1:0] back_out_q;

	logic accept;
	logic s1_done;

	dq_pkg::mode_t                    op;
	logic                             cnt_empty;
	logic                             cnt_full;
	logic                             cnt_multi;
	logic [IW-1:0]                    head_inc;
	logic [IW-1:0]                    head_dec;
	logic [SW-1:0]                    tail_sum;
	logic [SW-1:0]                    prev_sum;
	logic [SW-1:0]                    tail_wrap;
	logic [SW-1:0]                    prev_wrap;

	logic                             wr_en;
	logic [IW-1:0]                    wr_idx;
	logic                             rd_en;
	logic [IW-1:0]                    rd_idx;
	logic [dq_pkg::DATA_W-1:0]        rd_data;
	logic [IW-1:0]                    head_d;
	logic [CW-1:0]                    count_d;
	logic signed [dq_pkg::DATA_W-1:0] front_d;
	logic signed [dq_pkg::DATA_W-1:0] back_d;
	logic signed [dq_pkg::DATA_W-1:0] popped_d;
	dq_pkg::status_t                  status_d;
	logic                             ld_front_d;
	logic                             ld_back_d;

	logic                             res_empty;

	assign in_stall = valid_s1;
	assign accept   = in_valid & ~valid_s1;
	assign s1_done  = valid_s1 & (~out_valid_q | ~out_stall);

	assign op        = dq_pkg::mode_t'(mode);
	assign cnt_empty = (count_q == '0);
	assign cnt_full  = (count_q == FULL_CNT);
	assign cnt_multi = (count_q > CW'(1));
	assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
	assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - IW'(1);

	// slot past the back, and the slot before the back
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign prev_sum  = tail_sum - SW'(2);
	assign tail_wrap = (tail_sum >= WRAP_SUM) ? tail_sum - WRAP_SUM : tail_sum;
	assign prev_wrap = (prev_sum >= WRAP_SUM) ? prev_sum - WRAP_SUM : prev_sum;

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = tail_wrap[IW-1:0];
		rd_en      = 1'b0;
		rd_idx     = head_inc;
		head_d     = head_q;
		count_d    = count_q;
		front_d    = front_q;
		back_d     = back_q;
		popped_d   = '0;
		status_d   = dq_pkg::ST_OK;
		ld_front_d = 1'b0;
		ld_back_d  = 1'b0;
		unique case (op)
			dq_pkg::MODE_PUSH_BACK: begin
				if (cnt_full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					back_d  = push_value;
					if (cnt_empty) begin
						front_d = push_value;
					end
				end
			end
			dq_pkg::MODE_PUSH_FRONT: begin
				wr_idx = head_dec;
				if (cnt_full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					head_d  = head_dec;
					count_d = count_q + CW'(1);
					front_d = push_value;
					if (cnt_empty) begin
						back_d = push_value;
					end
				end
			end
			dq_pkg::MODE_POP_FRONT: begin
				if (cnt_empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					popped_d   = front_q;
					head_d     = head_inc;
					count_d    = count_q - CW'(1);
					rd_en      = cnt_multi;
					ld_front_d = cnt_multi;
				end
			end
			dq_pkg::MODE_POP_BACK: begin
				rd_idx = prev_wrap[IW-1:0];
				if (cnt_empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					popped_d  = back_q;
					count_d   = count_q - CW'(1);
					rd_en     = cnt_multi;
					ld_back_d = cnt_multi;
				end
			end
			default: begin
				status_d = dq_pkg::ST_OK;
			end
		endcase
	end

	dq_store #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (accept & wr_en),
		.wr_idx  (wr_idx),
		.wr_data (push_value),
		.rd_en   (accept & rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// front and back words: set by pushes at accept, reloaded from memory after a pop; in-flight fields load at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q     <= front_d;
			back_q      <= back_d;
			popped_s1   <= popped_d;
			status_s1   <= status_d;
			ld_front_s1 <= ld_front_d;
			ld_back_s1  <= ld_back_d;
		end else if (s1_done) begin
			if (ld_front_s1) begin
				front_q <= rd_data;
			end
			if (ld_back_s1) begin
				back_q <= rd_data;
			end
		end
	end

	assign res_empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (s1_done) begin
			popped_q    <= popped_s1;
			status_q    <= status_s1;
			empty_q     <= res_empty;
			full_q      <= (count_q == FULL_CNT);
			front_out_q <= res_empty ? '0 : (ld_front_s1 ? rd_data : front_q);
			back_out_q  <= res_empty ? '0 : (ld_back_s1 ? rd_data : back_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign is_empty     = empty_q;
	assign is_full      = full_q;
	assign front_value  = front_out_q;
	assign back_value   = back_out_q;

endmodule

`default_nettype wire

// ----- src/dq_store.sv -----
// Entry storage of the queue: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dq_store #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
	parameter int IW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [IW-1:0]             wr_idx,
	input  wire logic [dq_pkg::DATA_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [IW-1:0]             rd_idx,
	output logic      [dq_pkg::DATA_W-1:0] rd_data
);

	logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [dq_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- test/double_ended_queue_tb.sv -----
// Self-checking testbench for the double-ended queue: directed table, then random traffic.
`timescale 1ns / 1ps

module double_ended_queue_tb;

	localparam int DEPTH       = dq_pkg::DEPTH_DEFAULT;
	localparam int RANDOM_OPS  = 922;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [31:0]     popped;
		dq_pkg::status_t stat;
		logic            empty;
		logic            full;
		logic [31:0]     front;
		logic [31:0]     back;
	} deque_result_t;

	typedef struct {
		dq_pkg::mode_t op;
		logic [31:0]   word;
		bit            fixed;
		deque_result_t want;
	} plan_row_t;

	localparam deque_result_t NONE =
		'{32'd0, dq_pkg::ST_OK, 1'b0, 1'b0, 32'd0, 32'd0};
	localparam deque_result_t DRY  =
		'{32'd0, dq_pkg::ST_EMPTY, 1'b1, 1'b0, 32'd0, 32'd0};

	localparam int PLAN_ROWS = 28;
	plan_row_t plan [PLAN_ROWS] = '{
		'{dq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1, DRY},
		'{dq_pkg::MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, DRY},
		'{dq_pkg::MODE_PUSH_BACK,  32'h7FFF_FFFF, 1'b1,
			'{32'd0, dq_pkg::ST_OK, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		'{dq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1'b1,
			'{32'd0, dq_pkg::ST_OK, 1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF}},
		'{dq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1,
			'{32'h8000_0000, dq_pkg::ST_OK, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		'{dq_pkg::MODE_POP_BACK,   32'h0000_0000, 1'b1,
			'{32'h7FFF_FFFF, dq_pkg::ST_OK, 1'b1, 1'b0, 32'd0, 32'd0}},
		'{dq_pkg::MODE_PUSH_FRONT, 32'h0000_0000, 1'b0, NONE},
		'{dq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1,
			'{32'd0, dq_pkg::ST_OK, 1'b1, 1'b0, 32'd0, 32'd0}},
		// fill to the brim from both ends
		'{dq_pkg::MODE_PUSH_BACK,  32'h0000_0001, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h5555_5555, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h1234_5678, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'h8765_4321, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h0000_0100, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FF00, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h7FFF_0000, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'h8000_FFFF, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h0000_0002, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFD, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'h3C3C_3C3C, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'hC3C3_C3C3, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_BACK,  32'hDEAD_BEEF, 1'b0, NONE},
		'{dq_pkg::MODE_PUSH_FRONT, 32'h0123_4567, 1'b0, NONE},
		'{dq_pkg::MODE_POP_BACK,   32'h0000_0000, 1'b0, NONE},
		'{dq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b0, NONE}
	};

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [1:0]         mode       = dq_pkg::MODE_PUSH_BACK;
	logic signed [31:0] push_value = 32'sd0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic               is_empty;
	logic               is_full;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;

	// shadow copy of the ring
	logic [31:0]   ring_words [DEPTH];
	int unsigned   ring_head;
	int unsigned   ring_held;

	deque_result_t pending_results [$];
	int            mismatch_count = 0;
	int            result_count   = 0;
	int            cycle_count    = 0;
	bit            quiet;
	int            stall_left;

	double_ended_queue #(.DEPTH(DEPTH)) uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic deque_result_t step_deque(input dq_pkg::mode_t op,
			input logic [31:0] word);
		deque_result_t r;
		r = NONE;
		case (op)
			dq_pkg::MODE_PUSH_BACK, dq_pkg::MODE_PUSH_FRONT: begin
				if (ring_held == DEPTH) begin
					r.stat = dq_pkg::ST_FULL;
				end else begin
					if (op == dq_pkg::MODE_PUSH_BACK) begin
						ring_words[(ring_head + ring_held) % DEPTH] = word;
					end else begin
						ring_head = (ring_head + DEPTH - 1) % DEPTH;
						ring_words[ring_head] = word;
					end
					ring_held++;
				end
			end
			default: begin
				if (ring_held == 0) begin
					r.stat = dq_pkg::ST_EMPTY;
				end else begin
					if (op == dq_pkg::MODE_POP_FRONT) begin
						r.popped  = ring_words[ring_head];
						ring_head = (ring_head + 1) % DEPTH;
					end else begin
						r.popped = ring_words[(ring_head + ring_held - 1) % DEPTH];
					end
					ring_held--;
				end
			end
		endcase
		r.empty = (ring_held == 0);
		r.full  = (ring_held == DEPTH);
		if (ring_held != 0) begin
			r.front = ring_words[ring_head];
			r.back  = ring_words[(ring_head + ring_held - 1) % DEPTH];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d result %0d: %s", cycle_count, result_count, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
	endtask

	// Present one operation, hold it until the transfer, then log its expected result.
	task automatic transfer_op(input plan_row_t row);
		deque_result_t r;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= row.op;
		push_value <= row.word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = step_deque(row.op, row.word);
		pending_results.insert(pending_results.size(), row.fixed ? row.want : r);
	endtask

	// Receiver stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("popped_value", popped_value, want.popped);
				check_field("status", {30'd0, status}, {30'd0, want.stat});
				check_field("is_empty", {31'd0, is_empty}, {31'd0, want.empty});
				check_field("is_full", {31'd0, is_full}, {31'd0, want.full});
				check_field("front_value", front_value, want.front);
				check_field("back_value", back_value, want.back);
			end
			result_count++;
		end
	end

	initial begin
		plan_row_t   row;
		int unsigned push_pct;
		logic [31:0] edge_words [4];
		edge_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
		ring_head      = 0;
		ring_held      = 0;
		quiet          = 1'b0;
		push_pct       = 50;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			transfer_op(plan[i]);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			// drift the push share every 32 transfers to hit both full and empty
			if (n % 32 == 0)
				push_pct = 10 + 20 * $urandom_range(0, 4);
			quiet = (n >= 400 && n < 480) || (n >= RANDOM_OPS - 150);
			row = '{dq_pkg::MODE_PUSH_BACK, 32'd0, 1'b0, NONE};
			if ($urandom_range(0, 99) < push_pct)
				row.op = $urandom_range(0, 1) ? dq_pkg::MODE_PUSH_FRONT
					: dq_pkg::MODE_PUSH_BACK;
			else
				row.op = $urandom_range(0, 1) ? dq_pkg::MODE_POP_FRONT
					: dq_pkg::MODE_POP_BACK;
			if ($urandom_range(0, 15) == 0)
				row.word = edge_words[$urandom_range(0, 3)];
			else
				row.word = $urandom;
			transfer_op(row);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- double_ended_queue.f -----
src/dq_pkg.sv
src/dq_store.sv
src/double_ended_queue.sv
test/double_ended_queue_tb.sv
